// File: src/lesf_pkg.sv
// shared constants and types for the largest empty square finder
package lesf_pkg;

    localparam int MAX_POINTS = 128;
    localparam int COORD_BITS = 16;
    localparam int ADDR_BITS  = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int SIDE_BITS  = COORD_BITS + 1;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_COMPUTE = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORNER,
        ST_CLATCH,
        ST_SCAN,
        ST_EVAL
    } t_state;

endpackage

// File: src/largest_empty_square_finder_unit.sv
// top level of the largest empty square finder
//
//  channel   ports                                         transfer when
//  command   start, busy, i_func, i_tree_x, i_tree_y       start && !busy
//  result    o_valid, o_corner_x/y, o_side, o_dropped      o_valid (one cycle)
//  config    i_cfg_we, i_cfg_idx, i_cfg_data               i_cfg_we
//
// a load can follow every cycle while the block is not busy
// a compute walks all (n+1)*(n+1) corner candidates for n stored trees,
// scanning the trees through the single read port of each coordinate store,
// once per corner candidate; the result is strobed the cycle after the final evaluation
// reset is synchronous, active low, and empties the store; no clearing pass
// results are strobed for one cycle and cannot be stalled
module largest_empty_square_finder_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_func,
    input  logic [lesf_pkg::COORD_BITS-1:0]     i_tree_x,
    input  logic [lesf_pkg::COORD_BITS-1:0]     i_tree_y,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [lesf_pkg::COORD_BITS-1:0]     i_cfg_data,
    output logic                                o_valid,
    output logic [lesf_pkg::COORD_BITS-1:0]     o_corner_x,
    output logic [lesf_pkg::COORD_BITS-1:0]     o_corner_y,
    output logic [lesf_pkg::COORD_BITS-1:0]     o_side,
    output logic                                o_dropped
);

    localparam int CB = lesf_pkg::COORD_BITS;
    localparam int NB = lesf_pkg::CNT_BITS;
    localparam int AB = lesf_pkg::ADDR_BITS;
    localparam int SB = lesf_pkg::SIDE_BITS;

    // coordinate stores
    logic [CB-1:0] mem_x [lesf_pkg::MAX_POINTS];
    logic [CB-1:0] mem_y [lesf_pkg::MAX_POINTS];
    logic [CB-1:0] rd_x, rd_y;
    logic [AB-1:0] ra_x, ra_y;

    lesf_pkg::t_state r_state, n_state;
    logic [CB-1:0] r_w, r_h;
    logic [NB-1:0] r_count, n_count;
    logic          r_drop, n_drop;
    logic [NB-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic          r_pv, n_pv;
    logic [CB-1:0] r_cx, n_cx, r_cy, n_cy;
    logic signed [SB-1:0] r_s, n_s;
    logic [CB-1:0] r_best, n_best, r_bx, n_bx, r_by, n_by;
    logic          r_valid, n_valid;
    logic [CB-1:0] r_ox, n_ox, r_oy, n_oy, r_os, n_os;
    logic          r_od, n_od;

    logic          load_ok, wr_en;
    logic [CB-1:0] dx, dy, dmax, s_pos;
    logic          win;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= '1;
            r_h <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lesf_pkg::REG_WIDTH:  r_w <= i_cfg_data;
                lesf_pkg::REG_HEIGHT: r_h <= i_cfg_data;
                default:              r_w <= r_w;
            endcase
        end
    end

    // load qualification
    assign load_ok = (i_tree_x <= r_w) && (i_tree_y <= r_h)
                     && (r_count < NB'(lesf_pkg::MAX_POINTS));
    assign wr_en   = start && !busy && (i_func == lesf_pkg::FUNC_LOAD) && load_ok;

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_x[r_count[AB-1:0]] <= i_tree_x;
            mem_y[r_count[AB-1:0]] <= i_tree_y;
        end
        rd_x <= mem_x[ra_x];
        rd_y <= mem_y[ra_y];
    end

    // read addresses: corner fetch or tree scan
    always_comb begin
        if (r_state == lesf_pkg::ST_SCAN) begin
            ra_x = r_k[AB-1:0];
            ra_y = r_k[AB-1:0];
        end else begin
            ra_x = r_i[AB-1:0];
            ra_y = r_j[AB-1:0];
        end
    end

    // distance from corner to scanned tree
    assign dx    = rd_x - r_cx;
    assign dy    = rd_y - r_cy;
    assign dmax  = (dy > dx) ? dy : dx;
    assign s_pos = r_s[SB-1] ? '0 : r_s[CB-1:0];
    assign win   = (s_pos > r_best)
                   || ((s_pos == r_best) && (s_pos != '0)
                       && ((r_cx < r_bx) || ((r_cx == r_bx) && (r_cy < r_by))));

    // sequencer
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_drop  = r_drop;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_pv    = 1'b0;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_s     = r_s;
        n_best  = r_best;
        n_bx    = r_bx;
        n_by    = r_by;
        n_valid = 1'b0;
        n_ox    = r_ox;
        n_oy    = r_oy;
        n_os    = r_os;
        n_od    = r_od;
        case (r_state)
            lesf_pkg::ST_IDLE: begin
                if (start) begin
                    if (i_func == lesf_pkg::FUNC_LOAD) begin
                        if (load_ok) n_count = r_count + NB'(1);
                        else         n_drop  = 1'b1;
                    end else begin
                        n_i     = '0;
                        n_j     = '0;
                        n_best  = '0;
                        n_bx    = '0;
                        n_by    = '0;
                        n_state = lesf_pkg::ST_CORNER;
                    end
                end
            end
            lesf_pkg::ST_CORNER: begin
                n_state = lesf_pkg::ST_CLATCH;
            end
            lesf_pkg::ST_CLATCH: begin
                n_cx    = (r_i == r_count) ? '0 : rd_x;
                n_cy    = (r_j == r_count) ? '0 : rd_y;
                n_s     = ($signed({1'b0, r_w}) - $signed({1'b0, n_cx}) <
                           $signed({1'b0, r_h}) - $signed({1'b0, n_cy}))
                          ? $signed({1'b0, r_w}) - $signed({1'b0, n_cx})
                          : $signed({1'b0, r_h}) - $signed({1'b0, n_cy});
                n_k     = '0;
                n_state = lesf_pkg::ST_SCAN;
            end
            lesf_pkg::ST_SCAN: begin
                if (r_k < r_count) begin
                    n_k  = r_k + NB'(1);
                    n_pv = 1'b1;
                end
                if (r_pv && (rd_x > r_cx) && (rd_y > r_cy)
                    && ($signed({1'b0, dmax}) < r_s)) begin
                    n_s = $signed({1'b0, dmax});
                end
                if ((r_k == r_count) && !r_pv) n_state = lesf_pkg::ST_EVAL;
            end
            lesf_pkg::ST_EVAL: begin
                if (win) begin
                    n_best = s_pos;
                    n_bx   = r_cx;
                    n_by   = r_cy;
                end
                if (r_j == r_count) begin
                    n_j = '0;
                    if (r_i == r_count) begin
                        n_valid = 1'b1;
                        n_ox    = win ? r_cx : r_bx;
                        n_oy    = win ? r_cy : r_by;
                        n_os    = win ? s_pos : r_best;
                        n_od    = r_drop;
                        n_count = '0;
                        n_drop  = 1'b0;
                        n_state = lesf_pkg::ST_IDLE;
                    end else begin
                        n_i     = r_i + NB'(1);
                        n_state = lesf_pkg::ST_CORNER;
                    end
                end else begin
                    n_j     = r_j + NB'(1);
                    n_state = lesf_pkg::ST_CORNER;
                end
            end
            default: n_state = lesf_pkg::ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lesf_pkg::ST_IDLE;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_valid <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
            r_valid <= n_valid;
            r_pv    <= n_pv;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_k    <= n_k;
        r_cx   <= n_cx;
        r_cy   <= n_cy;
        r_s    <= n_s;
        r_best <= n_best;
        r_bx   <= n_bx;
        r_by   <= n_by;
        r_ox   <= n_ox;
        r_oy   <= n_oy;
        r_os   <= n_os;
        r_od   <= n_od;
    end

    assign busy       = (r_state != lesf_pkg::ST_IDLE);
    assign o_valid    = r_valid;
    assign o_corner_x = r_ox;
    assign o_corner_y = r_oy;
    assign o_side     = r_os;
    assign o_dropped  = r_od;

`ifndef ASSERT_OFF
    // a result leaves the store empty
    a_empty_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_count == '0) && !r_drop)
        else $error("store not emptied after result");

    // a compute transfer makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == lesf_pkg::FUNC_COMPUTE) |=> busy)
        else $error("compute did not start");

    // fill count never passes capacity
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NB'(lesf_pkg::MAX_POINTS))
        else $error("store overfilled");

    // a result only comes from the final evaluation
    a_res_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == lesf_pkg::ST_EVAL)
        else $error("stray result strobe");
`endif

endmodule

// File: verif/largest_empty_square_finder_unit_test.sv
// self-checking testbench for the largest empty square finder
`timescale 1ns / 100ps

module largest_empty_square_finder_unit_test;

    localparam int CB = lesf_pkg::COORD_BITS;

    typedef struct packed {
        logic [CB-1:0] corner_x;
        logic [CB-1:0] corner_y;
        logic [CB-1:0] side;
        logic          dropped;
    } t_square;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic          i_func;
    logic [CB-1:0] i_tree_x;
    logic [CB-1:0] i_tree_y;
    logic          i_cfg_we;
    logic          i_cfg_idx;
    logic [CB-1:0] i_cfg_data;
    logic          o_valid;
    logic [CB-1:0] o_corner_x;
    logic [CB-1:0] o_corner_y;
    logic [CB-1:0] o_side;
    logic          o_dropped;

    // shadow copy of the block state
    logic [CB-1:0] tree_xs [lesf_pkg::MAX_POINTS];
    logic [CB-1:0] tree_ys [lesf_pkg::MAX_POINTS];
    int            tree_count;
    bit            drop_flag;
    logic [CB-1:0] fld_w;
    logic [CB-1:0] fld_h;

    t_square pending_squares[$];
    int      mismatches;
    bit      no_gaps;

    largest_empty_square_finder_unit u_top (.*);

    // clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // side of the empty square with lower-left corner at (cx, cy)
    function automatic longint side_from(longint cx, longint cy);
        longint s;
        longint d;
        s = longint'(fld_w) - cx;
        if (longint'(fld_h) - cy < s) s = longint'(fld_h) - cy;
        for (int k = 0; k < tree_count; k++) begin
            if (tree_xs[k] > cx && tree_ys[k] > cy) begin
                d = tree_xs[k] - cx;
                if (tree_ys[k] - cy > d) d = tree_ys[k] - cy;
                if (d < s) s = d;
            end
        end
        if (s < 0) s = 0;
        return s;
    endfunction

    // update the shadow state for one accepted command
    function automatic void predict_square(logic func, logic [CB-1:0] tx,
                                           logic [CB-1:0] ty);
        longint  best;
        longint  bx;
        longint  by;
        longint  cx;
        longint  cy;
        longint  s;
        t_square sq;
        best = 0; bx = 0; by = 0;
        if (func == lesf_pkg::FUNC_LOAD) begin
            if (tx > fld_w || ty > fld_h || tree_count >= lesf_pkg::MAX_POINTS) begin
                drop_flag = 1'b1;
            end else begin
                tree_xs[tree_count] = tx;
                tree_ys[tree_count] = ty;
                tree_count++;
            end
            return;
        end
        for (int i = 0; i <= tree_count; i++) begin
            cx = (i == tree_count) ? 0 : longint'(tree_xs[i]);
            for (int j = 0; j <= tree_count; j++) begin
                cy = (j == tree_count) ? 0 : longint'(tree_ys[j]);
                s = side_from(cx, cy);
                if (s > best ||
                    (s == best && s > 0 && (cx < bx || (cx == bx && cy < by)))) begin
                    best = s; bx = cx; by = cy;
                end
            end
        end
        sq.corner_x = bx[CB-1:0];
        sq.corner_y = by[CB-1:0];
        sq.side     = best[CB-1:0];
        sq.dropped  = drop_flag;
        pending_squares = {pending_squares, sq};
        tree_count = 0;
        drop_flag  = 1'b0;
    endfunction

    // check each result against the oldest expected square
    always @(posedge i_clk) begin
        t_square exp_sq;
        if (i_rst_n && o_valid) begin
            if (pending_squares.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at %0t: got x=%0d y=%0d side=%0d drop=%0d",
                             $time, o_corner_x, o_corner_y, o_side, o_dropped);
            end else begin
                exp_sq = pending_squares.pop_front();
                if (exp_sq.corner_x !== o_corner_x || exp_sq.corner_y !== o_corner_y ||
                    exp_sq.side !== o_side || exp_sq.dropped !== o_dropped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: exp x=%0d y=%0d side=%0d drop=%0d, %s",
                                 $time, exp_sq.corner_x, exp_sq.corner_y, exp_sq.side,
                                 exp_sq.dropped,
                                 $sformatf("got x=%0d y=%0d side=%0d drop=%0d",
                                           o_corner_x, o_corner_y, o_side, o_dropped));
                end
            end
        end
    end

    // one command transfer, with a random gap in front unless no_gaps is set
    task automatic send_cmd(logic func, logic [CB-1:0] tx, logic [CB-1:0] ty);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start    = 1'b1;
        i_func   = func;
        i_tree_x = tx;
        i_tree_y = ty;
        do @(posedge i_clk); while (busy);
        predict_square(func, tx, ty);
    endtask

    task automatic load_tree(logic [CB-1:0] tx, logic [CB-1:0] ty);
        send_cmd(lesf_pkg::FUNC_LOAD, tx, ty);
    endtask

    task automatic compute_square();
        send_cmd(lesf_pkg::FUNC_COMPUTE, CB'($urandom()), CB'($urandom()));
    endtask

    // let the block drain before touching the registers
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_squares.size() != 0 || busy) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_field(logic [CB-1:0] w, logic [CB-1:0] h);
        drain();
        i_cfg_we   = 1'b1;
        i_cfg_idx  = lesf_pkg::REG_WIDTH;
        i_cfg_data = w;
        @(negedge i_clk);
        i_cfg_idx  = lesf_pkg::REG_HEIGHT;
        i_cfg_data = h;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        fld_w = w;
        fld_h = h;
    endtask

    // empty store, extremes, corner ties, out-of-field drops
    task automatic test_directed();
        compute_square();
        load_tree(16'd0, 16'd0);
        load_tree(16'hFFFF, 16'hFFFF);
        load_tree(16'h8000, 16'h7FFF);
        compute_square();
        write_field(16'd0, 16'd0);
        compute_square();
        load_tree(16'd1, 16'd0);
        compute_square();
        write_field(16'd10, 16'd6);
        load_tree(16'd3, 16'd3);
        load_tree(16'd7, 16'd2);
        load_tree(16'd11, 16'd1);
        load_tree(16'd2, 16'd7);
        compute_square();
        load_tree(16'd5, 16'd5);
        load_tree(16'd5, 16'd5);
        load_tree(16'd0, 16'd6);
        compute_square();
    endtask

    // stored trees left beyond a shrunk field
    task automatic test_field_shrink();
        write_field(16'd100, 16'd100);
        load_tree(16'd90, 16'd90);
        load_tree(16'd60, 16'd20);
        load_tree(16'd20, 16'd70);
        write_field(16'd50, 16'd40);
        compute_square();
    endtask

    // full store, then one more tree
    task automatic test_store_full();
        write_field(16'hFFFF, 16'hFFFF);
        no_gaps = 1'b1;
        for (int k = 0; k <= lesf_pkg::MAX_POINTS; k++)
            load_tree(CB'($urandom()), CB'($urandom()));
        compute_square();
        no_gaps = 1'b0;
    endtask

    // random small tree sets across several field settings
    task automatic test_random();
        int sent;
        int n;
        logic [CB-1:0] w;
        logic [CB-1:0] h;
        sent = 0;
        while (sent < 1400) begin
            case ($urandom_range(0, 4))
                0: begin w = 16'hFFFF; h = 16'hFFFF; end
                1: begin w = CB'($urandom_range(0, 3)); h = CB'($urandom_range(0, 3)); end
                2: begin w = CB'($urandom_range(0, 20)); h = CB'($urandom_range(0, 20)); end
                default: begin w = CB'($urandom()); h = CB'($urandom()); end
            endcase
            write_field(w, h);
            repeat ($urandom_range(5, 15)) begin
                no_gaps = ($urandom_range(0, 3) == 0);
                n = $urandom_range(0, 7);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(0, 9) == 0)
                        load_tree(CB'($urandom()), CB'($urandom()));
                    else
                        load_tree(CB'($urandom_range(0, w)), CB'($urandom_range(0, h)));
                end
                compute_square();
                sent += n + 1;
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        start = 1'b0; i_func = lesf_pkg::FUNC_LOAD; i_tree_x = '0; i_tree_y = '0;
        i_cfg_we = 1'b0; i_cfg_idx = lesf_pkg::REG_WIDTH; i_cfg_data = '0;
        i_rst_n = 1'b0;
        mismatches = 0; no_gaps = 1'b0;
        tree_count = 0; drop_flag = 1'b0;
        fld_w = 16'hFFFF; fld_h = 16'hFFFF;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_field_shrink();
        test_random();
        test_store_full();
        drain();
        repeat (20) @(negedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #200_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
src/lesf_pkg.sv
src/largest_empty_square_finder_unit.sv
verif/largest_empty_square_finder_unit_test.sv
